// ----- hdl/stc_pkg.sv -----
// shared types, constants and character classes for the source tokenizer
`timescale 1ns / 1ps

package stc_pkg;

    localparam logic [2:0] KIND_IDENT     = 3'd0;
    localparam logic [2:0] KIND_NUMBER    = 3'd1;
    localparam logic [2:0] KIND_OPERATOR  = 3'd2;
    localparam logic [2:0] KIND_DELIMITER = 3'd3;
    localparam logic [2:0] KIND_NEWLINE   = 3'd4;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } scan_mode_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] start_position;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic [7:0]  token_char;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [15:0] clamp16(input logic [31:0] v);
        return (|v[31:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == CHAR_PLUS || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
               c == 8'h25 || c == 8'h24 || c == 8'h40 || c == CHAR_COLON;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D ||
               c == 8'h5B || c == 8'h5D || c == 8'h3C || c == 8'h3E ||
               c == 8'h2C || c == 8'h3B || c == CHAR_DOT || c == CHAR_EQUAL;
    endfunction

endpackage

// ----- hdl/stc_stream_if.sv -----
// valid/ready channel interfaces for characters in and tokens out
`timescale 1ns / 1ps

interface stc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_text;

    modport source (output valid, output character, output end_of_text, input ready);
    modport sink (input valid, input character, input end_of_text, output ready);
endinterface

interface stc_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] start_position;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  token_char;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_position,
                    output token_length, output line_number, output column_number,
                    output token_char, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_position,
                  input token_length, input line_number, input column_number,
                  input token_char, input last_of_run, output ready);
endinterface

// ----- hdl/stc_scan_core.sv -----
// scanner state, character classification and token formation
`timescale 1ns / 1ps

module stc_scan_core #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     character,
    input  logic           end_of_text,
    output stc_pkg::push_t push
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
        return (&v) ? v : v + CNT_ONE;
    endfunction

    stc_pkg::scan_mode_t     mode_reg, mode_next;
    logic [COUNTER_WIDTH-1:0] run_start_reg, run_start_next;
    logic [COUNTER_WIDTH-1:0] run_column_reg, run_column_next;
    logic [COUNTER_WIDTH-1:0] run_line_reg, run_line_next;
    logic [COUNTER_WIDTH-1:0] run_length_reg, run_length_next;
    logic [COUNTER_WIDTH-1:0] position_reg, position_next;
    logic [COUNTER_WIDTH-1:0] line_reg, line_next;
    logic [COUNTER_WIDTH-1:0] column_reg, column_next;

    logic letter, digit, keeps, closing, fresh, single;
    stc_pkg::result_t res_a, res_b;

    assign letter = stc_pkg::is_letter(character);
    assign digit  = stc_pkg::is_digit(character);

    always_comb
    begin
        keeps = 1'b0;
        if (!end_of_text)
        begin
            case (mode_reg)
                stc_pkg::MODE_IDENT:  keeps = letter || digit;
                stc_pkg::MODE_NUMBER: keeps = digit || character == stc_pkg::CHAR_DOT;
                default:              keeps = 1'b0;
            endcase
        end
    end

    assign closing = !keeps && mode_reg != stc_pkg::MODE_IDLE;
    assign fresh   = !end_of_text && !keeps;
    assign single  = fresh && (character == stc_pkg::CHAR_NEWLINE ||
                               stc_pkg::is_op(character) || stc_pkg::is_delim(character));

    always_comb
    begin
        res_a.token_kind     = (mode_reg == stc_pkg::MODE_IDENT) ? stc_pkg::KIND_IDENT
                                                                 : stc_pkg::KIND_NUMBER;
        res_a.start_position = stc_pkg::clamp16(32'(run_start_reg));
        res_a.token_length   = stc_pkg::clamp16(32'(run_length_reg));
        res_a.line_number    = stc_pkg::clamp16(32'(run_line_reg));
        res_a.column_number  = stc_pkg::clamp16(32'(run_column_reg));
        res_a.token_char     = 8'd0;
        res_a.last_of_run    = !single;

        // operator reading of colon wins over delimiter
        if (character == stc_pkg::CHAR_NEWLINE)
            res_b.token_kind = stc_pkg::KIND_NEWLINE;
        else if (stc_pkg::is_op(character))
            res_b.token_kind = stc_pkg::KIND_OPERATOR;
        else
            res_b.token_kind = stc_pkg::KIND_DELIMITER;
        res_b.start_position = stc_pkg::clamp16(32'(position_reg));
        res_b.token_length   = 16'd1;
        res_b.line_number    = stc_pkg::clamp16(32'(line_reg));
        res_b.column_number  = stc_pkg::clamp16(32'(column_reg));
        res_b.token_char     = character;
        res_b.last_of_run    = 1'b1;

        push.count  = 2'(closing) + 2'(single);
        push.first  = closing ? res_a : res_b;
        push.second = res_b;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        run_start_next  = run_start_reg;
        run_column_next = run_column_reg;
        run_line_next   = run_line_reg;
        run_length_next = run_length_reg;
        position_next   = position_reg;
        line_next       = line_reg;
        column_next     = column_reg;
        if (step)
        begin
            if (end_of_text)
            begin
                mode_next = stc_pkg::MODE_IDLE;
            end
            else if (keeps)
            begin
                run_length_next = sat_inc(run_length_reg);
                position_next   = sat_inc(position_reg);
                column_next     = sat_inc(column_reg);
            end
            else
            begin
                mode_next     = stc_pkg::MODE_IDLE;
                position_next = sat_inc(position_reg);
                if (character == stc_pkg::CHAR_NEWLINE)
                begin
                    line_next   = sat_inc(line_reg);
                    column_next = CNT_ONE;
                end
                else
                begin
                    column_next = sat_inc(column_reg);
                    if (letter || digit)
                    begin
                        mode_next       = letter ? stc_pkg::MODE_IDENT : stc_pkg::MODE_NUMBER;
                        run_start_next  = position_reg;
                        run_column_next = column_reg;
                        run_line_next   = line_reg;
                        run_length_next = CNT_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stc_pkg::MODE_IDLE;
            run_start_reg  <= '0;
            run_column_reg <= CNT_ONE;
            run_line_reg   <= CNT_ONE;
            run_length_reg <= CNT_ONE;
            position_reg   <= '0;
            line_reg       <= CNT_ONE;
            column_reg     <= CNT_ONE;
        end
        else
        begin
            mode_reg       <= mode_next;
            run_start_reg  <= run_start_next;
            run_column_reg <= run_column_next;
            run_line_reg   <= run_line_next;
            run_length_reg <= run_length_next;
            position_reg   <= position_next;
            line_reg       <= line_next;
            column_reg     <= column_next;
        end
    end

    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |=> mode_reg == stc_pkg::MODE_IDLE)
        else $error("end of text left a run open");

    a_two_starts_with_run: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.first.token_kind == stc_pkg::KIND_IDENT ||
                                push.first.token_kind == stc_pkg::KIND_NUMBER))
        else $error("pair of results does not start with a run token");

    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> line_reg >= $past(line_reg))
        else $error("line counter went backward");

endmodule

// ----- hdl/stc_result_queue.sv -----
// two-entry result queue that takes up to two results per cycle
`timescale 1ns / 1ps

module stc_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  stc_pkg::push_t    push,
    output logic [1:0]        space,
    output logic              head_valid,
    output stc_pkg::result_t  head,
    input  logic              pop
);

    stc_pkg::result_t slot_reg [2];
    stc_pkg::result_t slot_next [2];
    logic [1:0]       count_reg, count_next;
    logic [1:0]       kept;

    assign head_valid = count_reg != 2'd0;
    assign head       = slot_reg[0];
    assign space      = 2'd2 - count_reg + 2'(pop && head_valid);

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        kept         = count_reg;
        if (pop && head_valid)
        begin
            slot_next[0] = slot_reg[1];
            kept         = count_reg - 2'd1;
        end
        count_next = kept;
        if (push_en && push.count != 2'd0)
        begin
            slot_next[kept[0]] = push.first;
            if (push.count == 2'd2)
                slot_next[1] = push.second;
            count_next = kept + push.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

// ----- hdl/source_char_tokenizer.sv -----
// top level of the streaming source tokenizer
// a character request is first held in the input register; once the queue has space, its results
//   are written into the result queue, whose head drives the token output
// throughput: one character per cycle while the result queue has space; a character
//   that closes a run and makes a single-character token queues a second result
// the two-entry result queue sets when a character can leave the input register
// reset: run closed, position 0, line and column 1, queue and input register empty
`timescale 1ns / 1ps

module source_char_tokenizer #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    stc_char_if.sink    char_in,
    stc_token_if.source token_out
);

    logic             in_valid_reg;
    logic [7:0]       char_reg;
    logic             eot_reg;
    logic             step;
    logic [1:0]       space;
    logic             head_valid;
    logic             pop;
    stc_pkg::push_t   push;
    stc_pkg::result_t head;

    assign step          = in_valid_reg && push.count <= space;
    assign char_in.ready = !in_valid_reg || step;
    assign pop           = token_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_in.ready)
            in_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            char_reg <= char_in.character;
            eot_reg  <= char_in.end_of_text;
        end
    end

    stc_scan_core #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .character   (char_reg),
        .end_of_text (eot_reg),
        .push        (push)
    );

    stc_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (step),
        .push       (push),
        .space      (space),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    assign token_out.valid          = head_valid;
    assign token_out.token_kind     = head.token_kind;
    assign token_out.start_position = head.start_position;
    assign token_out.token_length   = head.token_length;
    assign token_out.line_number    = head.line_number;
    assign token_out.column_number  = head.column_number;
    assign token_out.token_char     = head.token_char;
    assign token_out.last_of_run    = head.last_of_run;

    a_pair_stays: assert property (@(posedge clk) disable iff (!rst_n)
        token_out.valid && token_out.ready && !token_out.last_of_run |=> token_out.valid)
        else $error("second result of a request missing");

    a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(char_reg) && $stable(eot_reg))
        else $error("stalled character lost");

    a_no_empty_push: assert property (@(posedge clk) disable iff (!rst_n)
        step && push.count != 2'd0 |=> token_out.valid)
        else $error("token request not queued");

endmodule

// ----- dv/source_char_tokenizer_tb.sv -----
// self-checking testbench for the source tokenizer: directed, random and back-pressure
`timescale 1ns / 1ps

module source_char_tokenizer_tb;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int RANDOM_ITEMS = 1160;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stc_char_if  char_bus ();
    stc_token_if token_bus ();

    source_char_tokenizer #(
        .COUNTER_WIDTH(16)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .token_out(token_bus)
    );

    // tokenizer state as predicted
    stc_pkg::scan_mode_t scan_q;
    logic [15:0] run_start_q;
    logic [15:0] run_col_q;
    logic [15:0] run_line_q;
    logic [15:0] run_len_q;
    logic [15:0] pos_q;
    logic [15:0] line_q;
    logic [15:0] col_q;

    stc_pkg::result_t pending_tokens[$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_off_cycles;
    int chars_sent;
    int tokens_checked;
    int mismatches;
    int cycle_count;

    string       op_chars    = "+-*/%$@:";
    string       delim_chars = "(){}[]<>,;.=";
    logic [7:0]  blank_chars [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic char_alpha(input logic [7:0] c);
        return c inside {["A":"Z"], ["a":"z"]};
    endfunction

    function automatic logic char_numeric(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic char_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, stc_pkg::CHAR_NEWLINE, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic char_operator(input logic [7:0] c);
        return c inside {stc_pkg::CHAR_PLUS, "-", "*", "/", "%", "$", "@",
                         stc_pkg::CHAR_COLON};
    endfunction

    function automatic logic char_delimiter(input logic [7:0] c);
        return c inside {"(", ")", "{", "}", "[", "]", "<", ">", ",", ";",
                         stc_pkg::CHAR_DOT, stc_pkg::CHAR_EQUAL};
    endfunction

    function automatic stc_pkg::result_t make_token(input logic [2:0] kind,
                                                    input logic [15:0] start,
                                                    input logic [15:0] len,
                                                    input logic [15:0] line,
                                                    input logic [15:0] col,
                                                    input logic [7:0] ch);
        stc_pkg::result_t t;
        t.token_kind     = kind;
        t.start_position = start;
        t.token_length   = len;
        t.line_number    = line;
        t.column_number  = col;
        t.token_char     = ch;
        t.last_of_run    = 1'b0;
        return t;
    endfunction

    task automatic tokenize_char(input logic [7:0] c, input logic eot);
        stc_pkg::result_t step_tokens [2];
        int      n;
        logic    keeps;
        n = 0;
        keeps = 1'b0;
        if (!eot)
        begin
            if (scan_q == stc_pkg::MODE_IDENT)
                keeps = char_alpha(c) || char_numeric(c);
            else if (scan_q == stc_pkg::MODE_NUMBER)
                keeps = char_numeric(c) || c == stc_pkg::CHAR_DOT;
        end
        if (keeps)
        begin
            run_len_q = bump(run_len_q);
            pos_q = bump(pos_q);
            col_q = bump(col_q);
        end
        else
        begin
            if (scan_q != stc_pkg::MODE_IDLE)
            begin
                step_tokens[n] = make_token((scan_q == stc_pkg::MODE_IDENT) ?
                                            stc_pkg::KIND_IDENT : stc_pkg::KIND_NUMBER,
                                            run_start_q, run_len_q, run_line_q, run_col_q,
                                            8'h00);
                n++;
            end
            scan_q = stc_pkg::MODE_IDLE;
            if (!eot)
            begin
                if (c == stc_pkg::CHAR_NEWLINE)
                begin
                    step_tokens[n] = make_token(stc_pkg::KIND_NEWLINE, pos_q, 16'd1, line_q,
                                                col_q, c);
                    n++;
                    line_q = bump(line_q);
                    col_q = 16'd1;
                    pos_q = bump(pos_q);
                end
                else
                begin
                    if (char_alpha(c) || char_numeric(c))
                    begin
                        scan_q = char_alpha(c) ? stc_pkg::MODE_IDENT : stc_pkg::MODE_NUMBER;
                        run_start_q = pos_q;
                        run_col_q = col_q;
                        run_line_q = line_q;
                        run_len_q = 16'd1;
                    end
                    else if (!char_space(c) && (char_operator(c) || char_delimiter(c)))
                    begin
                        step_tokens[n] = make_token(char_operator(c) ? stc_pkg::KIND_OPERATOR
                                                                     : stc_pkg::KIND_DELIMITER,
                                                    pos_q, 16'd1, line_q, col_q, c);
                        n++;
                    end
                    pos_q = bump(pos_q);
                    col_q = bump(col_q);
                end
            end
        end
        if (n > 0)
            step_tokens[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_tokens.push_back(step_tokens[i]);
    endtask

    always @(posedge clk)
    begin : check_tokens
        stc_pkg::result_t got;
        stc_pkg::result_t want;
        if (rst_n)
        begin
            if (char_bus.valid && char_bus.ready)
                tokenize_char(char_bus.character, char_bus.end_of_text);
            if (token_bus.valid && token_bus.ready)
            begin
                got = {token_bus.token_kind, token_bus.start_position, token_bus.token_length,
                       token_bus.line_number, token_bus.column_number, token_bus.token_char,
                       token_bus.last_of_run};
                tokens_checked++;
                if (pending_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected token, expected none, actual %p", $time, got);
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: token mismatch, expected %p, actual %p",
                                 $time, want, got);
                    end
                end
            end
        end
    end

    // receiver: random stalls plus a counted hold-off
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            token_bus.ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else
        begin
            token_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < src_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.character <= c;
        char_bus.end_of_text <= eot;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic wait_for_tokens();
        char_bus.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'($urandom_range(1) ? $urandom_range("Z", "A") : $urandom_range("z", "a"));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range("9", "0"));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(2) == 0) ? pick_digit() : pick_letter();
    endfunction

    // mostly well-formed lexemes, some noise bytes and end-of-text requests
    task automatic send_fragment();
        int r;
        int n;
        r = $urandom_range(99);
        n = $urandom_range(6);
        if (r < 30)
        begin
            send_item(pick_letter(), 1'b0);
            repeat (n) send_item(pick_alnum(), 1'b0);
        end
        else if (r < 50)
        begin
            send_item(pick_digit(), 1'b0);
            repeat (n) send_item(($urandom_range(3) == 0) ? stc_pkg::CHAR_DOT : pick_digit(),
                                 1'b0);
        end
        else if (r < 62)
            send_item(op_chars[$urandom_range(op_chars.len() - 1)], 1'b0);
        else if (r < 74)
            send_item(delim_chars[$urandom_range(delim_chars.len() - 1)], 1'b0);
        else if (r < 82)
            send_item(blank_chars[$urandom_range(4)], 1'b0);
        else if (r < 88)
            send_item(stc_pkg::CHAR_NEWLINE, 1'b0);
        else if (r < 92)
            send_item(8'($urandom_range(255)), 1'b1);
        else
            send_item(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_directed();
        string s;
        src_idle_pct = 33;
        sink_idle_pct = 51;
        s = "Ab9.7..3:=+\n \t";
        foreach (s[i])
            send_item(s[i], 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h0B, 1'b0);
        send_item(8'h0C, 1'b0);
        send_item("z", 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item("5", 1'b0);
        send_item(stc_pkg::CHAR_NEWLINE, 1'b0);
        send_item(8'h0D, 1'b0);
        send_item("q", 1'b0);
        send_item("~", 1'b0);
        wait_for_tokens();
    endtask

    task automatic test_backpressure();
        int start;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_off_cycles = 300;
        start = chars_sent;
        while (chars_sent - start < 60)
            send_fragment();
        wait_for_tokens();
    endtask

    task automatic test_random();
        int start;
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 51 : 0;
            sink_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 33 : 0;
            start = chars_sent;
            while (chars_sent - start < RANDOM_ITEMS / 3)
                send_fragment();
            wait_for_tokens();
        end
    endtask

    initial
    begin
        char_bus.valid = 1'b0;
        char_bus.character = 8'h00;
        char_bus.end_of_text = 1'b0;
        token_bus.ready = 1'b0;
        scan_q = stc_pkg::MODE_IDLE;
        run_start_q = 16'd0;
        run_col_q = 16'd1;
        run_line_q = 16'd1;
        run_len_q = 16'd1;
        pos_q = 16'd0;
        line_q = 16'd1;
        col_q = 16'd1;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_off_cycles = 0;
        chars_sent = 0;
        tokens_checked = 0;
        mismatches = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();

        $display("sent %0d character requests, checked %0d tokens", chars_sent, tokens_checked);
        $display("covered every character class, run closing, end of text and output stalls");
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
